// ----- src/scba_pkg.sv -----
// shared types and constants of the size-class slot allocator
package scba_pkg;

   // field widths fixed by the command and result formats
   localparam int SIZE_W       = 16;
   localparam int CNT_FIELD_W  = 6;
   localparam int POOL_W       = 2;
   localparam int SLOT_FIELD_W = 5;
   localparam int STAT_W       = 32;
   localparam int CSR_IDX_W    = 3;
   localparam int NUM_POOLS    = 3;

   // pool selectors
   localparam logic [POOL_W-1:0] POOL_SMALL  = 2'd0;
   localparam logic [POOL_W-1:0] POOL_MEDIUM = 2'd1;
   localparam logic [POOL_W-1:0] POOL_LARGE  = 2'd2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_SMALL_SIZE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MEDIUM_SIZE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LARGE_SIZE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SMALL_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MEDIUM_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LARGE_COUNT  = 3'd5;

   // reset values of the slot sizes and counts
   localparam logic [SIZE_W-1:0]      RESET_SMALL_SIZE  = 16'd64;
   localparam logic [SIZE_W-1:0]      RESET_MEDIUM_SIZE = 16'd256;
   localparam logic [SIZE_W-1:0]      RESET_LARGE_SIZE  = 16'd1024;
   localparam logic [CNT_FIELD_W-1:0] RESET_COUNT       = 6'd32;

   typedef enum logic [1:0] {
      CMD_ALLOC     = 2'd0,
      CMD_FREE      = 2'd1,
      CMD_READ_HIST = 2'd2,
      CMD_READ_EXH  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_TOO_LARGE = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   // one command beat
   typedef struct packed {
      cmd_type                   command;
      logic [SIZE_W-1:0]         capacity;
      logic [POOL_W-1:0]         pool;
      logic [CNT_FIELD_W-1:0]    slot_index;
   } req_type;

   // one result beat, plus the flag that takes stat from the histogram
   typedef struct packed {
      status_type                status;
      logic [POOL_W-1:0]         granted_pool;
      logic [SLOT_FIELD_W-1:0]   granted_slot;
      logic [SIZE_W-1:0]         granted_capacity;
      logic [STAT_W-1:0]         stat_value;
      logic                      hist_sel;
   } rsp_type;

   // histogram memory access for one beat
   typedef struct packed {
      logic rd_en;
      logic inc;
   } hist_ctrl_type;

endpackage

// ----- src/scba_pool_ctrl.sv -----
// pool state, allocate and free decisions and exhaustion counters
module scba_pool_ctrl import scba_pkg::*; #(
   parameter int MAX_SLOTS    = 32,
   parameter int COUNTER_BITS = 32,
   localparam int CNT_W        = $clog2(MAX_SLOTS + 1),
   localparam int SLOT_W       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
   localparam int HIST_DEPTH   = MAX_SLOTS + 1,
   localparam int HIST_ENTRIES = NUM_POOLS * HIST_DEPTH,
   localparam int HA_W         = $clog2(HIST_ENTRIES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]     csr_data,
   input  logic                  item_vld,
   input  req_type               item,
   output rsp_type               res_in,
   output logic [HA_W-1:0]       hist_addr,
   output hist_ctrl_type         hist_ctrl
);

   logic [SIZE_W-1:0]       size_ff  [NUM_POOLS];
   logic [CNT_W-1:0]        count_ff [NUM_POOLS];
   logic [CNT_W-1:0]        nfree_ff [NUM_POOLS];
   logic [MAX_SLOTS-1:0]    map_ff   [NUM_POOLS];
   logic [COUNTER_BITS-1:0] exh_ff   [NUM_POOLS];

   logic [NUM_POOLS-1:0] fit;
   logic [NUM_POOLS-1:0] nonempty;
   logic [NUM_POOLS-1:0] bump;
   logic                 found;
   logic [POOL_W-1:0]    gp;
   logic [MAX_SLOTS-1:0] gmap;
   logic [SLOT_W-1:0]    gslot;
   logic [CNT_W-1:0]     used;
   logic [POOL_W-1:0]    psel;
   logic                 pool_bad;
   logic                 free_bad;
   logic                 hist_bad;
   logic [SLOT_W-1:0]    fslot;

   // count register value, clamped to the pool depth
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_FIELD_W-1:0] v);
      logic [CNT_W-1:0] c;
      if (v > CNT_FIELD_W'(MAX_SLOTS)) begin
         c = CNT_W'(MAX_SLOTS);
      end else begin
         c = CNT_W'(v);
      end
      return c;
   endfunction

   // free bitmap with the low count bits set
   function automatic logic [MAX_SLOTS-1:0] full_map(input logic [CNT_W-1:0] c);
      logic [MAX_SLOTS-1:0] m;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         m[i] = CNT_W'(i) < c;
      end
      return m;
   endfunction

   // first histogram entry of a pool
   function automatic logic [HA_W-1:0] pool_base(input logic [POOL_W-1:0] p);
      return HA_W'(p) * HA_W'(HIST_DEPTH);
   endfunction

   // pool search: first fitting pool with a free slot, small before medium before large
   always_comb begin
      found = 1'b0;
      gp    = POOL_SMALL;
      for (int p = 0; p < NUM_POOLS; p++) begin
         fit[p]      = item.capacity <= size_ff[p];
         nonempty[p] = |map_ff[p];
         bump[p]     = fit[p] && !found && !nonempty[p];
         if (fit[p] && nonempty[p] && !found) begin
            found = 1'b1;
            gp    = POOL_W'(p);
         end
      end
   end

   // lowest free slot and occupancy after the grant
   always_comb begin
      gmap  = map_ff[gp];
      gslot = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (gmap[i]) begin
            gslot = SLOT_W'(i);
         end
      end
      used = count_ff[gp] - nfree_ff[gp] + CNT_W'(1);
   end

   // free and read checks
   always_comb begin
      pool_bad = item.pool >= POOL_W'(NUM_POOLS);
      psel     = pool_bad ? POOL_SMALL : item.pool;
      fslot    = item.slot_index[SLOT_W-1:0];
      free_bad = pool_bad || (item.slot_index >= CNT_FIELD_W'(count_ff[psel])) ||
                 map_ff[psel][fslot];
      hist_bad = pool_bad || (item.slot_index > CNT_FIELD_W'(count_ff[psel]));
   end

   // result of this beat
   always_comb begin
      res_in          = '0;
      res_in.status   = ST_OK;
      hist_addr       = '0;
      hist_ctrl.rd_en = 1'b0;
      hist_ctrl.inc   = 1'b0;
      case (item.command)
         CMD_ALLOC: begin
            if (found) begin
               res_in.granted_pool     = gp;
               res_in.granted_slot     = SLOT_FIELD_W'(gslot);
               res_in.granted_capacity = size_ff[gp];
               hist_addr               = pool_base(gp) + HA_W'(used);
               hist_ctrl.rd_en         = item_vld;
               hist_ctrl.inc           = item_vld;
            end else if (|fit) begin
               res_in.status = ST_FULL;
            end else begin
               res_in.status = ST_TOO_LARGE;
            end
         end
         CMD_FREE: begin
            if (free_bad) begin
               res_in.status = ST_BAD_INDEX;
            end
         end
         CMD_READ_HIST: begin
            if (hist_bad) begin
               res_in.status = ST_BAD_INDEX;
            end else begin
               res_in.hist_sel = 1'b1;
               hist_addr       = pool_base(psel) + HA_W'(item.slot_index);
               hist_ctrl.rd_en = item_vld;
            end
         end
         CMD_READ_EXH: begin
            if (pool_bad) begin
               res_in.status = ST_BAD_INDEX;
            end else begin
               res_in.stat_value = STAT_W'(exh_ff[psel]);
            end
         end
         default: begin
            res_in.status = ST_OK;
         end
      endcase
   end

   // pool state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= RESET_SMALL_SIZE;
         size_ff[1] <= RESET_MEDIUM_SIZE;
         size_ff[2] <= RESET_LARGE_SIZE;
         for (int p = 0; p < NUM_POOLS; p++) begin
            count_ff[p] <= clamp_count(RESET_COUNT);
            nfree_ff[p] <= clamp_count(RESET_COUNT);
            map_ff[p]   <= full_map(clamp_count(RESET_COUNT));
            exh_ff[p]   <= '0;
         end
      end else begin
         if (item_vld) begin
            case (item.command)
               CMD_ALLOC: begin
                  for (int p = 0; p < NUM_POOLS; p++) begin
                     if (bump[p]) begin
                        exh_ff[p] <= exh_ff[p] + COUNTER_BITS'(1);
                     end
                  end
                  if (found) begin
                     map_ff[gp][gslot] <= 1'b0;
                     nfree_ff[gp]      <= nfree_ff[gp] - CNT_W'(1);
                  end
               end
               CMD_FREE: begin
                  if (!free_bad) begin
                     map_ff[psel][fslot] <= 1'b1;
                     nfree_ff[psel]      <= nfree_ff[psel] + CNT_W'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         // register writes must only arrive while idle; the block does not enforce this
         if (csr_we) begin
            unique case (csr_index)
               REG_SMALL_SIZE:   size_ff[0] <= csr_data;
               REG_MEDIUM_SIZE:  size_ff[1] <= csr_data;
               REG_LARGE_SIZE:   size_ff[2] <= csr_data;
               REG_SMALL_COUNT: begin
                  count_ff[0] <= clamp_count(csr_data[CNT_FIELD_W-1:0]);
                  nfree_ff[0] <= clamp_count(csr_data[CNT_FIELD_W-1:0]);
                  map_ff[0]   <= full_map(clamp_count(csr_data[CNT_FIELD_W-1:0]));
               end
               REG_MEDIUM_COUNT: begin
                  count_ff[1] <= clamp_count(csr_data[CNT_FIELD_W-1:0]);
                  nfree_ff[1] <= clamp_count(csr_data[CNT_FIELD_W-1:0]);
                  map_ff[1]   <= full_map(clamp_count(csr_data[CNT_FIELD_W-1:0]));
               end
               REG_LARGE_COUNT: begin
                  count_ff[2] <= clamp_count(csr_data[CNT_FIELD_W-1:0]);
                  nfree_ff[2] <= clamp_count(csr_data[CNT_FIELD_W-1:0]);
                  map_ff[2]   <= full_map(clamp_count(csr_data[CNT_FIELD_W-1:0]));
               end
               default: begin
               end
            endcase
         end
      end
   end

   // free count tracks the bitmap
   a_nfree_match: assert property (@(posedge clock) disable iff (reset)
      (nfree_ff[0] == CNT_W'($countones(map_ff[0]))) &&
      (nfree_ff[1] == CNT_W'($countones(map_ff[1]))) &&
      (nfree_ff[2] == CNT_W'($countones(map_ff[2]))))
      else $error("free count out of step with bitmap");

   // no free bit above the pool count
   a_map_in_range: assert property (@(posedge clock) disable iff (reset)
      ((map_ff[0] >> count_ff[0]) == '0) &&
      ((map_ff[1] >> count_ff[1]) == '0) &&
      ((map_ff[2] >> count_ff[2]) == '0))
      else $error("free bit beyond pool count");

endmodule

// ----- src/scba_hist_ram.sv -----
// occupancy histogram memory with valid bits and increment write-back
module scba_hist_ram import scba_pkg::*; #(
   parameter int MAX_SLOTS    = 32,
   parameter int COUNTER_BITS = 32,
   localparam int HIST_DEPTH   = MAX_SLOTS + 1,
   localparam int HIST_ENTRIES = NUM_POOLS * HIST_DEPTH,
   localparam int HA_W         = $clog2(HIST_ENTRIES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hist_ctrl_type           ctrl,
   input  logic [HA_W-1:0]         rd_addr,
   output logic [COUNTER_BITS-1:0] value
);

   logic [COUNTER_BITS-1:0] hist_mem [HIST_ENTRIES];
   logic [HIST_ENTRIES-1:0] vld_ff;
   logic [COUNTER_BITS-1:0] rd_data_ff;
   logic                    rd_vld_ff;
   logic                    inc_ff;
   logic [HA_W-1:0]         addr_ff;
   logic [COUNTER_BITS-1:0] wr_data;
   logic                    bypass;

   // an entry never written reads as zero
   assign value   = rd_vld_ff ? rd_data_ff : '0;
   assign wr_data = value + COUNTER_BITS'(1);
   // a read of the entry being written back takes the new count
   assign bypass  = inc_ff && (addr_ff == rd_addr);

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (inc_ff) begin
         hist_mem[addr_ff] <= wr_data;
      end
      if (ctrl.rd_en) begin
         addr_ff <= rd_addr;
         if (bypass) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= hist_mem[rd_addr];
         end
      end
   end

   // valid bits and write-back control
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         inc_ff    <= 1'b0;
      end else begin
         inc_ff <= ctrl.rd_en && ctrl.inc;
         if (inc_ff) begin
            vld_ff[addr_ff] <= 1'b1;
         end
         if (ctrl.rd_en) begin
            rd_vld_ff <= bypass || vld_ff[rd_addr];
         end
      end
   end

endmodule

// ----- src/size_class_buffer_allocator.sv -----
// top level of the size-class slot allocator
// Three pools of fixed-size slots (small, medium, large) with free bitmaps.
// Each command beat gives one result beat on rsp_valid after the command
// register and the result register; a new command can be taken every
// cycle and busy stays low, so a stream runs at one beat per clock. The
// command is registered; pool search, bitmap and counter update and the
// histogram memory read follow; the result is then shown from registers
// while the histogram increment is written back. The receiver cannot stall
// results, so rsp_ beats must be captured on the cycle they appear.
// Register writes on the csr_ port are always ready and must only be issued
// while no command is in flight.
module size_class_buffer_allocator import scba_pkg::*; #(
   parameter int MAX_SLOTS    = 32,
   parameter int COUNTER_BITS = 32,
   localparam int HIST_ENTRIES = NUM_POOLS * (MAX_SLOTS + 1),
   localparam int HA_W         = $clog2(HIST_ENTRIES)
) (
   input  logic                    clock,
   input  logic                    reset,
   // command channel
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_command,
   input  logic [SIZE_W-1:0]       req_capacity,
   input  logic [POOL_W-1:0]       req_pool,
   input  logic [CNT_FIELD_W-1:0]  req_slot_index,
   // result channel
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [POOL_W-1:0]       rsp_granted_pool,
   output logic [SLOT_FIELD_W-1:0] rsp_granted_slot,
   output logic [SIZE_W-1:0]       rsp_granted_capacity,
   output logic [STAT_W-1:0]       rsp_stat_value,
   // register write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [SIZE_W-1:0]       csr_data
);

   logic                    accept;
   logic                    item_vld_ff;
   req_type                 item_ff;
   rsp_type                 res_in;
   rsp_type                 res_ff;
   logic                    rsp_vld_ff;
   logic [HA_W-1:0]         hist_addr;
   hist_ctrl_type           hist_ctrl;
   logic [COUNTER_BITS-1:0] hist_value;

   // every beat is taken at once
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // command register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.command    <= cmd_type'(req_command);
         item_ff.capacity   <= req_capacity;
         item_ff.pool       <= req_pool;
         item_ff.slot_index <= req_slot_index;
      end
   end

   scba_pool_ctrl #(
      .MAX_SLOTS    (MAX_SLOTS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_pool_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .item_vld  (item_vld_ff),
      .item      (item_ff),
      .res_in    (res_in),
      .hist_addr (hist_addr),
      .hist_ctrl (hist_ctrl)
   );

   scba_hist_ram #(
      .MAX_SLOTS    (MAX_SLOTS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_hist_ram (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (hist_ctrl),
      .rd_addr (hist_addr),
      .value   (hist_value)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= item_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_vld_ff) begin
         res_ff <= res_in;
      end
   end

   // result ports
   assign rsp_valid            = rsp_vld_ff;
   assign rsp_status           = res_ff.status;
   assign rsp_granted_pool     = res_ff.granted_pool;
   assign rsp_granted_slot     = res_ff.granted_slot;
   assign rsp_granted_capacity = res_ff.granted_capacity;
   assign rsp_stat_value       = res_ff.hist_sel ? STAT_W'(hist_value) : res_ff.stat_value;

   // every command beat gives a result beat through the command and result registers
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      accept && !reset |=> ##1 rsp_valid)
      else $error("result beat missing");

   // grant fields stay zero unless an allocate succeeds
   a_no_grant_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_granted_pool == '0) && (rsp_granted_slot == '0) &&
         (rsp_granted_capacity == '0))
      else $error("grant fields set on a failed beat");

   // a rejected beat carries no statistic
   a_bad_no_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BAD_INDEX) |-> (rsp_stat_value == '0))
      else $error("statistic on a rejected beat");

endmodule
